[hw/rtl/mdsa_pkg.sv]
`default_nettype none
// ============================================================================
// mdsa_pkg
// Shared types, constants, the leaf summary and the node merge function
// of the max-distance slot allocator.
// ============================================================================
package mdsa_pkg;

    localparam int MAX_SLOTS  = 1024;
    localparam int SLOT_W     = 11;   // slot number 1..1024
    localparam int IDX_W      = 10;   // slot minus one, memory address
    localparam int NODE_W     = 11;   // heap node index, leaves at 1024..2047
    localparam int DIST_W     = 10;
    localparam int CLIENT_W   = 10;
    localparam int LEVELS     = 10;   // tree levels above the leaves
    localparam int QCNT_W     = 4;

    localparam logic [SLOT_W-1:0] SLOTS_RESET = SLOT_W'(MAX_SLOTS);
    localparam logic [QCNT_W-1:0] QUERY_LAST  = QCNT_W'(LEVELS);
    localparam logic [QCNT_W-1:0] QUERY_END   = QCNT_W'(LEVELS + 1);
    localparam logic [NODE_W-1:0] ROOT_NODE   = NODE_W'(1);

    localparam logic MODE_ARRIVE = 1'b0;
    localparam logic MODE_DEPART = 1'b1;

    // One input word.
    typedef struct packed {
        logic                mode;
        logic [CLIENT_W-1:0] client_id;
    } in_word_t;

    // One result word.
    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic              no_room;
    } out_word_t;

    // Summary of a range of slots. A distance of zero means no candidate.
    typedef struct packed {
        logic              any;
        logic [SLOT_W-1:0] lm;
        logic [SLOT_W-1:0] rm;
        logic [DIST_W-1:0] d;
        logic [SLOT_W-1:0] p;
    } node_t;

    typedef struct packed {
        logic              en;
        logic [NODE_W-1:0] node;
    } rd_req_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        logic             occ;
    } leaf_wr_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        node_t            val;
    } tree_wr_t;

    localparam node_t EMPTY_NODE = '0;

    // Summary of a single slot.
    function automatic node_t leaf_node(logic occ, logic [SLOT_W-1:0] pos);
        node_t r;
        r     = EMPTY_NODE;
        r.any = occ;
        r.lm  = pos;
        r.rm  = pos;
        return r;
    endfunction

    // Combine a left range with the adjacent right range. Candidates are
    // ordered by position, so a later one wins only with a larger distance.
    function automatic node_t node_merge(node_t a, node_t b);
        node_t             r;
        logic [SLOT_W-1:0] gap;
        logic [SLOT_W:0]   psum;
        if (!a.any) begin
            r = b;
        end else if (!b.any) begin
            r = a;
        end else begin
            r.any = 1'b1;
            r.lm  = a.lm;
            r.rm  = b.rm;
            r.d   = a.d;
            r.p   = a.p;
            gap   = b.lm - a.rm;
            psum  = {1'b0, a.rm} + {1'b0, b.lm};
            if (DIST_W'(gap >> 1) > r.d) begin
                r.d = DIST_W'(gap >> 1);
                r.p = psum[SLOT_W:1];
            end
            if (b.d > r.d) begin
                r.d = b.d;
                r.p = b.p;
            end
        end
        return r;
    endfunction

endpackage
`default_nettype wire

[hw/rtl/max_distance_slot_allocator_core.sv]
`default_nettype none
// ============================================================================
// max_distance_slot_allocator_core
// Hands out the free slot farthest from every occupied slot and frees the
// slot of a departing client.
// ============================================================================
// Usage:
//   The input channel (in_valid, in_stall, in_word) takes one word at a time:
//   an arrival or a departure of a client. Each arrival yields one word on
//   the output channel (out_valid, out_stall, out_word) with the chosen slot,
//   or no_room set when the row is full. A departure yields no word.
//   The configuration channel (cfg_valid, cfg_ready, cfg_data) sets the
//   number of slots; it is always ready. The user must write it only
//   while the block idles; the block itself does not enforce this.
//   An arrival walks the summary tree over the configured prefix, picks
//   the slot, then rewrites the leaf and its ten ancestors, one level per
//   cycle through the node memory. The result is registered when the slot
//   is picked. One word is in work at a time. After reset the block
//   clears the node and occupancy memories with in_stall high. A stalled
//   result stays in the output register; the next word is still accepted
//   and runs until it needs that register.
// ============================================================================
module max_distance_slot_allocator_core (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  cfg_valid,
    output logic                 cfg_ready,
    input  wire  [10:0]          cfg_data,
    input  wire                  in_valid,
    output logic                 in_stall,
    input  mdsa_pkg::in_word_t   in_word,
    output logic                 out_valid,
    input  wire                  out_stall,
    output mdsa_pkg::out_word_t  out_word
);
    import mdsa_pkg::*;

    typedef enum logic [6:0] {
        S_CLEAR  = 7'b0000001,
        S_IDLE   = 7'b0000010,
        S_LOOKUP = 7'b0000100,
        S_QUERY  = 7'b0001000,
        S_DECIDE = 7'b0010000,
        S_UPD0   = 7'b0100000,
        S_UPD    = 7'b1000000
    } state_t;

    state_t               state_reg, state_next;
    logic [SLOT_W-1:0]    n_reg;
    logic [IDX_W-1:0]     clr_reg;
    logic [CLIENT_W-1:0]  cid_reg;
    logic [QCNT_W-1:0]    q_cnt_reg;
    logic [IDX_W-1:0]     qm_reg;
    logic [NODE_W-1:0]    k_reg;
    logic                 rd_pend_reg;
    logic                 rd_inc_reg;
    node_t                acc_reg;
    node_t                cur_reg;
    logic [NODE_W-1:0]    c_reg;
    logic                 occ_reg;
    logic                 out_valid_reg;
    out_word_t            out_reg;
    logic [IDX_W-1:0]     client_mem [MAX_SLOTS];
    logic [IDX_W-1:0]     client_rd_reg;

    rd_req_t              rd_req;
    leaf_wr_t             leaf_wr;
    tree_wr_t             tree_wr;
    node_t                rd_node;
    logic                 in_accept;
    logic                 out_free;
    logic [NODE_W-1:0]    parent;
    node_t                merged;
    logic [DIST_W-1:0]    best_d;
    logic [SLOT_W-1:0]    best_p;
    logic [SLOT_W-1:0]    edge_lo;
    logic [SLOT_W-1:0]    edge_hi;
    logic                 dec_full;
    logic [SLOT_W-1:0]    dec_slot;
    logic [SLOT_W-1:0]    cfg_clamped;

    mdsa_node_store u_store (
        .clk     (clk),
        .rd_req  (rd_req),
        .leaf_wr (leaf_wr),
        .tree_wr (tree_wr),
        .rd_node (rd_node)
    );

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_word  = out_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    // Count register write, clamped to the range 1 to the row size.
    always_comb
    begin
        cfg_clamped = cfg_data;
        if (cfg_data == '0)
        begin
            cfg_clamped = SLOT_W'(1);
        end
        else if (cfg_data > SLOTS_RESET)
        begin
            cfg_clamped = SLOTS_RESET;
        end
    end

    // Parent of the current path node and its new summary.
    assign parent = c_reg >> 1;
    assign merged = c_reg[0] ? node_merge(rd_node, cur_reg) : node_merge(cur_reg, rd_node);

    // Final choice: slot 1 edge, best inner gap, last slot edge.
    always_comb
    begin
        edge_lo = acc_reg.lm - SLOT_W'(1);
        edge_hi = n_reg - acc_reg.rm;
        best_d  = edge_lo[DIST_W-1:0];
        best_p  = SLOT_W'(1);
        if (acc_reg.d > best_d)
        begin
            best_d = acc_reg.d;
            best_p = acc_reg.p;
        end
        if (edge_hi[DIST_W-1:0] > best_d)
        begin
            best_d = edge_hi[DIST_W-1:0];
            best_p = n_reg;
        end
        if (!acc_reg.any)
        begin
            dec_full = 1'b0;
            dec_slot = SLOT_W'(1);
        end
        else
        begin
            dec_full = (best_d == '0);
            dec_slot = dec_full ? '0 : best_p;
        end
    end

    // Memory requests for each phase.
    always_comb
    begin
        rd_req  = '0;
        leaf_wr = '0;
        tree_wr = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                leaf_wr.en   = 1'b1;
                leaf_wr.addr = clr_reg;
                tree_wr.en   = 1'b1;
                tree_wr.addr = clr_reg;
                tree_wr.val  = EMPTY_NODE;
            end
            S_QUERY:
            begin
                if (q_cnt_reg < QUERY_END)
                begin
                    rd_req.en   = 1'b1;
                    rd_req.node = (q_cnt_reg < QUERY_LAST) ? {k_reg[NODE_W-2:0], 1'b0} : k_reg;
                end
            end
            S_UPD0:
            begin
                leaf_wr.en   = 1'b1;
                leaf_wr.addr = c_reg[IDX_W-1:0];
                leaf_wr.occ  = occ_reg;
                rd_req.en    = 1'b1;
                rd_req.node  = c_reg ^ NODE_W'(1);
            end
            S_UPD:
            begin
                tree_wr.en   = 1'b1;
                tree_wr.addr = parent[IDX_W-1:0];
                tree_wr.val  = merged;
                if (parent != ROOT_NODE)
                begin
                    rd_req.en   = 1'b1;
                    rd_req.node = parent ^ NODE_W'(1);
                end
            end
            default:
            begin
            end
        endcase
    end

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (clr_reg == '1)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = (in_word.mode == MODE_DEPART) ? S_LOOKUP : S_QUERY;
                end
            end
            S_LOOKUP:
            begin
                state_next = S_UPD0;
            end
            S_QUERY:
            begin
                if (q_cnt_reg == QUERY_END)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (out_free)
                begin
                    state_next = dec_full ? S_IDLE : S_UPD0;
                end
            end
            S_UPD0:
            begin
                state_next = S_UPD;
            end
            S_UPD:
            begin
                if (parent == ROOT_NODE)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            n_reg         <= SLOTS_RESET;
            out_valid_reg <= 1'b0;
            rd_pend_reg   <= 1'b0;
            q_cnt_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR)
            begin
                clr_reg <= clr_reg + IDX_W'(1);
            end
            if (cfg_valid && cfg_ready)
            begin
                n_reg <= cfg_clamped;
            end
            if (state_reg == S_DECIDE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            rd_pend_reg <= (state_reg == S_QUERY) && rd_req.en;
            if (in_accept)
            begin
                q_cnt_reg <= '0;
            end
            else if (state_reg == S_QUERY)
            begin
                q_cnt_reg <= q_cnt_reg + QCNT_W'(1);
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            cid_reg  <= in_word.client_id;
            qm_reg   <= n_reg[IDX_W-1:0] - IDX_W'(1);
            k_reg    <= ROOT_NODE;
            acc_reg  <= EMPTY_NODE;
        end
        // Prefix walk: take each left child that lies wholly inside.
        if (state_reg == S_QUERY)
        begin
            if (rd_req.en)
            begin
                rd_inc_reg <= (q_cnt_reg < QUERY_LAST) ? qm_reg[IDX_W-1] : 1'b1;
                if (q_cnt_reg < QUERY_LAST)
                begin
                    k_reg  <= {k_reg[NODE_W-2:0], qm_reg[IDX_W-1]};
                    qm_reg <= qm_reg << 1;
                end
            end
            if (rd_pend_reg && rd_inc_reg)
            begin
                acc_reg <= node_merge(acc_reg, rd_node);
            end
        end
        if (state_reg == S_DECIDE && out_free)
        begin
            out_reg.slot    <= dec_slot;
            out_reg.no_room <= dec_full;
            c_reg           <= {1'b1, dec_slot[IDX_W-1:0] - IDX_W'(1)};
            occ_reg         <= 1'b1;
        end
        if (state_reg == S_LOOKUP)
        begin
            c_reg   <= {1'b1, client_rd_reg};
            occ_reg <= 1'b0;
        end
        if (state_reg == S_UPD0)
        begin
            cur_reg <= leaf_node(occ_reg, {1'b0, c_reg[IDX_W-1:0]} + SLOT_W'(1));
        end
        if (state_reg == S_UPD)
        begin
            cur_reg <= merged;
            c_reg   <= parent;
        end
    end

    // Slot of each client, stored as slot minus one.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_DECIDE && out_free && !dec_full)
        begin
            client_mem[cid_reg] <= dec_slot[IDX_W-1:0] - IDX_W'(1);
        end
        if (in_accept)
        begin
            client_rd_reg <= client_mem[in_word.client_id];
        end
    end

`ifndef SYNTHESIS
    // A granted slot lies inside the configured row.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DECIDE && out_free && !dec_full)
            |-> (dec_slot >= SLOT_W'(1) && dec_slot <= n_reg))
        else $error("granted slot outside the row");

    // The update walk only runs below the root.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_UPD) |-> (c_reg > ROOT_NODE))
        else $error("update walk past the root");

    // A departure never produces a result word.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LOOKUP) |=> !(state_reg == S_DECIDE))
        else $error("departure reached the decision step");

    // The count stays in range.
    assert property (@(posedge clk) disable iff (!rst_n)
        (n_reg >= SLOT_W'(1) && n_reg <= SLOTS_RESET))
        else $error("slot count out of range");
`endif

endmodule
`default_nettype wire

[hw/rtl/mdsa_node_store.sv]
`default_nettype none
// ============================================================================
// mdsa_node_store
// Holds the slot occupancy bits and the internal nodes of the summary tree,
// and returns any node, leaf or internal, as a summary in the cycle after
// the read request.
// ============================================================================
module mdsa_node_store (
    input  wire                 clk,
    input  mdsa_pkg::rd_req_t   rd_req,
    input  mdsa_pkg::leaf_wr_t  leaf_wr,
    input  mdsa_pkg::tree_wr_t  tree_wr,
    output mdsa_pkg::node_t     rd_node
);
    import mdsa_pkg::*;

    node_t             tree_mem [MAX_SLOTS];
    logic              occ_mem  [MAX_SLOTS];
    node_t             tree_rd_reg;
    logic              occ_rd_reg;
    logic              leaf_sel_reg;
    logic [SLOT_W-1:0] pos_reg;

    // Internal node memory.
    always_ff @(posedge clk)
    begin
        if (tree_wr.en)
        begin
            tree_mem[tree_wr.addr] <= tree_wr.val;
        end
        if (rd_req.en)
        begin
            tree_rd_reg <= tree_mem[rd_req.node[IDX_W-1:0]];
        end
    end

    // Occupancy memory, one bit per slot.
    always_ff @(posedge clk)
    begin
        if (leaf_wr.en)
        begin
            occ_mem[leaf_wr.addr] <= leaf_wr.occ;
        end
        if (rd_req.en)
        begin
            occ_rd_reg   <= occ_mem[rd_req.node[IDX_W-1:0]];
            leaf_sel_reg <= rd_req.node[NODE_W-1];
            pos_reg      <= {1'b0, rd_req.node[IDX_W-1:0]} + SLOT_W'(1);
        end
    end

    // Leaves are turned into a summary on the way out.
    assign rd_node = leaf_sel_reg ? leaf_node(occ_rd_reg, pos_reg) : tree_rd_reg;

endmodule
`default_nettype wire
